### src/wcf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wcf_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] site;
    logic        spin_value;
  } in_t;

  typedef struct packed {
    logic        spin_out;
    logic [12:0] cluster_size;
    logic [12:0] abs_spin_sum;
  } out_t;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLUST = 2'd2;
  localparam logic [1:0] MODE_MAG   = 2'd3;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic ADDR_THRESHOLD = 1'b0;
  localparam logic ADDR_SEED      = 1'b1;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_SITE_RD,
    ST_SITE_FIN,
    ST_DIV,
    ST_SEED_RD,
    ST_SEED_WR,
    ST_NB_RD,
    ST_NB_CHK,
    ST_POP_RD,
    ST_POP_LD,
    ST_CSUM,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic init_step;
    logic load_item;
    logic site_fin;
    logic div_step;
    logic seed_rd;
    logic seed_wr;
    logic nb_rd;
    logic nb_chk;
    logic pop_load;
    logic csum;
    logic resp_load;
  } cmd_t;

  typedef struct packed {
    logic       init_last;
    logic [1:0] mode;
    logic       site_ok;
    logic       dir_last;
    logic       pop_done;
    logic       out_free;
  } sts_t;

  typedef struct packed {
    logic        load;
    logic [31:0] value;
  } seed_ld_t;

endpackage

`default_nettype wire

### src/wcf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module wcf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/wcf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wcf_ctrl
  import wcf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!sts.site_ok || sts.mode == MODE_MAG) begin
          state_nxt = ST_RESP;
        end else if (sts.mode == MODE_CLUST) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_SITE_RD;
        end
      end
      ST_SITE_RD: state_nxt = ST_SITE_FIN;
      ST_SITE_FIN: begin
        cmd.site_fin = 1'b1;
        state_nxt    = ST_RESP;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_SEED_RD;
      end
      ST_SEED_RD: begin
        cmd.seed_rd = 1'b1;
        state_nxt   = ST_SEED_WR;
      end
      ST_SEED_WR: begin
        cmd.seed_wr = 1'b1;
        state_nxt   = ST_NB_RD;
      end
      ST_NB_RD: begin
        cmd.nb_rd = 1'b1;
        state_nxt = ST_NB_CHK;
      end
      ST_NB_CHK: begin
        cmd.nb_chk = 1'b1;
        if (!sts.dir_last) begin
          state_nxt = ST_NB_RD;
        end else if (sts.pop_done) begin
          state_nxt = ST_CSUM;
        end else begin
          state_nxt = ST_POP_RD;
        end
      end
      ST_POP_RD: state_nxt = ST_POP_LD;
      ST_POP_LD: begin
        cmd.pop_load = 1'b1;
        state_nxt    = ST_NB_RD;
      end
      ST_CSUM: begin
        cmd.csum  = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.resp_load = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

endmodule

`default_nettype wire

### src/wcf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module wcf_datapath
  import wcf_pkg::*;
#(
  parameter int SIDE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output sts_t             sts,
  input  wire in_t         in_data,
  input  wire logic [16:0] threshold,
  input  wire seed_ld_t    seed_ld,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data
);

  localparam int NSITES = SIDE * SIDE;
  localparam int RW     = $clog2(SIDE);
  localparam int AW     = $clog2(NSITES);
  localparam int TW     = AW + 1;
  localparam int SW     = AW + 2;
  localparam int QS     = 12 + RW;
  localparam int PW     = QS + RW;
  localparam logic [RW-1:0] ROW_MAX = RW'(SIDE - 1);
  localparam logic [TW-1:0] TOP_MAX = TW'(NSITES);
  localparam logic [SW-1:0] SUM_RST = SW'(NSITES % 2);
  localparam logic [12:0]   QM      = 13'(((1 << QS) + SIDE - 1) / SIDE);
  localparam logic [16:0]   NS_W    = 17'(NSITES);

  function automatic logic [AW-1:0] site_addr(input logic [RW-1:0] r, input logic [RW-1:0] c);
    return AW'(r * SIDE + c);
  endfunction

  logic [1:0]    mode_r;
  logic [11:0]   site_r;
  logic          val_r, site_ok_r;
  logic [RW-1:0] row_r, col_r, nbr_r, nbc_r, ir_r, ic_r;
  logic          old_r, spin_r;
  logic [1:0]    dir_r;
  logic [TW-1:0] top_r, top_nxt, rdp_r, csize_r;
  logic [31:0]   rng_r, rng_x;
  logic [SW-1:0] sum_r, abs_v;
  logic          out_valid_r;
  out_t          out_r;

  logic          lat_we, lat_wdata, lat_rdata;
  logic [AW-1:0] lat_waddr, lat_raddr;
  logic          stk_we;
  logic [AW-1:0] stk_waddr;
  logic [2*RW-1:0] stk_wdata, stk_rdata;
  logic [RW-1:0] nb_row, nb_col;
  logic [AW-1:0] site_a;
  logic [PW-1:0] quo;
  logic          same, hit, push;

  always_comb begin
    rng_x = rng_r ^ (rng_r << 13);
    rng_x = rng_x ^ (rng_x >> 17);
    rng_x = rng_x ^ (rng_x << 5);
  end

  always_comb begin
    nb_row = row_r;
    nb_col = col_r;
    case (dir_r)
      DIR_UP:    nb_row = (row_r == '0) ? ROW_MAX : row_r - RW'(1);
      DIR_DOWN:  nb_row = (row_r == ROW_MAX) ? '0 : row_r + RW'(1);
      DIR_LEFT:  nb_col = (col_r == '0) ? ROW_MAX : col_r - RW'(1);
      default:   nb_col = (col_r == ROW_MAX) ? '0 : col_r + RW'(1);
    endcase
  end

  // row = site / SIDE by reciprocal multiplication, exact for 12-bit sites
  assign site_a = AW'(site_r);
  assign quo    = PW'(site_r) * PW'(QM);

  assign same = (lat_rdata == old_r);
  assign hit  = cmd.nb_chk && same && ({1'b0, rng_x[31:16]} < threshold);
  assign push = hit && (top_r < TOP_MAX);

  always_comb begin
    top_nxt = top_r;
    if (cmd.seed_wr) top_nxt = TW'(1);
    else if (push)   top_nxt = top_r + TW'(1);
  end

  always_comb begin
    lat_we    = 1'b0;
    lat_waddr = site_a;
    lat_wdata = val_r;
    if (cmd.init_step) begin
      lat_we    = 1'b1;
      lat_waddr = site_addr(ir_r, ic_r);
      lat_wdata = ~(ir_r[0] ^ ic_r[0]);
    end else if (cmd.seed_wr) begin
      lat_we    = 1'b1;
      lat_wdata = ~lat_rdata;
    end else if (hit) begin
      lat_we    = 1'b1;
      lat_waddr = site_addr(nbr_r, nbc_r);
      lat_wdata = ~old_r;
    end else if (cmd.site_fin && mode_r == MODE_WRITE && lat_rdata != val_r) begin
      lat_we = 1'b1;
    end
  end

  assign lat_raddr = cmd.nb_rd ? site_addr(nb_row, nb_col) : site_a;

  always_comb begin
    stk_we    = cmd.seed_wr || push;
    stk_waddr = cmd.seed_wr ? '0 : top_r[AW-1:0];
    stk_wdata = cmd.seed_wr ? {row_r, col_r} : {nbr_r, nbc_r};
  end

  wcf_ram #(.WIDTH(1), .DEPTH(NSITES)) u_lattice (
    .clk   (clk),
    .we    (lat_we),
    .waddr (lat_waddr),
    .wdata (lat_wdata),
    .raddr (lat_raddr),
    .rdata (lat_rdata)
  );

  wcf_ram #(.WIDTH(2 * RW), .DEPTH(NSITES)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (rdp_r[AW-1:0]),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_r        <= '0;
      ic_r        <= '0;
      top_r       <= '0;
      rdp_r       <= '0;
      rng_r       <= 32'd1;
      sum_r       <= SUM_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.init_step) begin
        ic_r <= (ic_r == ROW_MAX) ? '0 : ic_r + RW'(1);
        if (ic_r == ROW_MAX) ir_r <= ir_r + RW'(1);
      end
      if (seed_ld.load) begin
        rng_r <= (seed_ld.value == '0) ? 32'd1 : seed_ld.value;
      end else if (cmd.nb_chk && same) begin
        rng_r <= rng_x;
      end
      top_r <= top_nxt;
      if (cmd.seed_wr) rdp_r <= '0;
      else if (cmd.nb_chk && dir_r == DIR_RIGHT) rdp_r <= rdp_r + TW'(1);
      if (cmd.csum) begin
        sum_r <= old_r ? sum_r - {top_r, 1'b0} : sum_r + {top_r, 1'b0};
      end else if (cmd.site_fin && mode_r == MODE_WRITE && lat_rdata != val_r) begin
        sum_r <= val_r ? sum_r + SW'(2) : sum_r - SW'(2);
      end
      if (cmd.resp_load)                 out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
    end
  end

  assign abs_v = sum_r[SW-1] ? -sum_r : sum_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r    <= in_data.mode;
      site_r    <= in_data.site;
      val_r     <= in_data.spin_value;
      site_ok_r <= 17'(in_data.site) < NS_W;
      spin_r    <= 1'b0;
      csize_r   <= '0;
    end
    if (cmd.div_step) row_r <= quo[QS +: RW];
    if (cmd.seed_rd) col_r <= RW'(site_a - site_addr(row_r, RW'(0)));
    if (cmd.seed_wr) begin
      old_r <= lat_rdata;
      dir_r <= DIR_UP;
    end
    if (cmd.nb_rd) begin
      nbr_r <= nb_row;
      nbc_r <= nb_col;
    end
    if (cmd.nb_chk) dir_r <= dir_r + 2'd1;
    if (cmd.pop_load) {row_r, col_r} <= stk_rdata;
    if (cmd.site_fin && mode_r == MODE_READ) spin_r <= lat_rdata;
    if (cmd.csum) csize_r <= top_r;
    if (cmd.resp_load) begin
      out_r.spin_out     <= spin_r;
      out_r.cluster_size <= 13'(csize_r);
      out_r.abs_spin_sum <= 13'(abs_v);
    end
  end

  always_comb begin
    sts.init_last = (ir_r == ROW_MAX) && (ic_r == ROW_MAX);
    sts.mode      = mode_r;
    sts.site_ok   = site_ok_r;
    sts.dir_last  = (dir_r == DIR_RIGHT);
    sts.pop_done  = (rdp_r + TW'(1)) >= top_nxt;
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TOP_MAX) else $error("stack top beyond lattice size");

  a_resp_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp_load |=> out_valid_r) else $error("result not presented");

  a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resp_load |-> sts.out_free) else $error("result overwritten");

  a_div_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> site_ok_r && mode_r == MODE_CLUST) else $error("bad cluster seed");

endmodule

`default_nettype wire

### src/ising_wolff_cluster_flip.sv
// Wolff cluster update engine on a periodic SIDE x SIDE Ising lattice held in a RAM. After
// reset a clearing pass writes the checkerboard, during which no transaction is accepted.
// Spin write and read pass through dispatch, a lattice RAM read and a finish step before the
// response; magnetization read and out-of-range sites skip straight to the response.
// A cluster update finds the seed's row and column, flips the seed, and makes four neighbor
// lookups per site on the lattice RAM read port; later sites are popped from the stack RAM.
// One transaction is processed at a time; a finished result waits in the output register
// while the next is accepted, and the next result is held back until that register is read.
`timescale 1ns / 1ps
`default_nettype none

module ising_wolff_cluster_flip
  import wcf_pkg::*;
#(
  parameter int SIDE = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [16:0] thr_r;
  logic [31:0] seed_r;
  logic        wr_en;
  seed_ld_t    seed_ld;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= 17'd32768;
      seed_r <= 32'd1;
    end else if (wr_en) begin
      if (paddr[2] == ADDR_THRESHOLD) thr_r  <= pwdata[16:0];
      else                             seed_r <= pwdata;
    end
  end

  assign prdata        = (paddr[2] == ADDR_SEED) ? seed_r : {15'b0, thr_r};
  assign seed_ld.load  = wr_en && (paddr[2] == ADDR_SEED);
  assign seed_ld.value = pwdata;

  wcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wcf_datapath #(.SIDE(SIDE)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .threshold (thr_r),
    .seed_ld   (seed_ld),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### bench/ising_wolff_cluster_flip_chk.sv
`timescale 1ns / 1ps

module ising_wolff_cluster_flip_chk
  import wcf_pkg::*;
#(
  parameter int SIDE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  localparam int NSITES = SIDE * SIDE;

  logic        spins [NSITES];
  int          cl_stack [NSITES];
  logic [16:0] bond_thr;
  logic [31:0] xs_state;
  int          mag_sum;
  out_t        expected_q[$];

  function automatic logic [15:0] next_uniform();
    logic [31:0] x;
    x = xs_state;
    x ^= x << 13;
    x ^= x >> 17;
    x ^= x << 5;
    xs_state = x;
    return x[31:16];
  endfunction

  function automatic int nb_site(int i, int dir);
    int row, col;
    row = i / SIDE;
    col = i % SIDE;
    case (dir)
      0: return (i + NSITES - SIDE) % NSITES;
      1: return (i + SIDE) % NSITES;
      2: return row * SIDE + (col + SIDE - 1) % SIDE;
      default: return row * SIDE + (col + 1) % SIDE;
    endcase
  endfunction

  function automatic int grow_cluster(int seed);
    logic oldspin;
    int top, rd, cur, n;
    oldspin = spins[seed];
    top = 0;
    rd = 0;
    cl_stack[top] = seed;
    top++;
    spins[seed] = ~oldspin;
    cur = seed;
    forever begin
      for (int d = 0; d < 4; d++) begin
        n = nb_site(cur, d);
        if (spins[n] == oldspin) begin
          if (next_uniform() < bond_thr) begin
            spins[n] = ~oldspin;
            if (top < NSITES) begin
              cl_stack[top] = n;
              top++;
            end
          end
        end
      end
      rd++;
      if (rd >= top) break;
      cur = cl_stack[rd];
    end
    mag_sum += (oldspin ? -2 : 2) * top;
    return top;
  endfunction

  function automatic out_t predict_item(in_t it);
    out_t r;
    bit ok;
    int a;
    r = '0;
    ok = it.site < NSITES;
    case (it.mode)
      MODE_WRITE: begin
        if (ok && spins[it.site] != it.spin_value) begin
          spins[it.site] = it.spin_value;
          mag_sum += it.spin_value ? 2 : -2;
        end
      end
      MODE_READ: begin
        if (ok) r.spin_out = spins[it.site];
      end
      MODE_CLUST: begin
        if (ok) r.cluster_size = 13'(grow_cluster(it.site));
      end
      default: ;
    endcase
    a = mag_sum < 0 ? -mag_sum : mag_sum;
    r.abs_spin_sum = 13'(a);
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    out_t exp_r;
    if (!rst_n) begin
      mag_sum = 0;
      for (int r = 0; r < SIDE; r++)
        for (int c = 0; c < SIDE; c++) begin
          spins[r * SIDE + c] = ((r + c) % 2) == 0;
          mag_sum += (((r + c) % 2) == 0) ? 1 : -1;
        end
      bond_thr = 17'd32768;
      xs_state = 32'd1;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == ADDR_SEED) xs_state = (pwdata == 0) ? 32'd1 : pwdata;
        else bond_thr = pwdata[16:0];
      end
      if (in_valid && in_ready) expected_q = {expected_q, predict_item(in_data)};
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected transaction: %p", out_data);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== out_data) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p, got %p", exp_r, out_data);
          end
        end
      end
    end
  end

endmodule

### bench/ising_wolff_cluster_flip_tb.sv
`timescale 1ns / 1ps

module ising_wolff_cluster_flip_tb;
  import wcf_pkg::*;

  localparam int SIDE = 64;
  localparam int NSITES = SIDE * SIDE;
  localparam longint LIMIT = 300_000_000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_t        out_data;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  longint      cycles = 0;
  int          idle_pct = 21;
  bit          hold_off = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  ising_wolff_cluster_flip #(.SIDE(SIDE)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ising_wolff_cluster_flip_chk #(.SIDE(SIDE)) chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("ising_wolff_cluster_flip verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else out_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
  end

  task automatic cfg_write(logic addr_sel, logic [31:0] v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {addr_sel, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic send(logic [1:0] m, logic [11:0] s, logic v);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{mode: m, site: s, spin_value: v};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic rand_item();
    int r;
    logic [11:0] s;
    r = $urandom_range(99);
    s = ($urandom_range(49) == 0) ? 12'($urandom) : 12'($urandom_range(NSITES - 1));
    if (r < 35) send(MODE_WRITE, s, 1'($urandom));
    else if (r < 60) send(MODE_READ, s, 1'($urandom));
    else if (r < 85) send(MODE_CLUST, s, 1'($urandom));
    else send(MODE_MAG, s, 1'($urandom));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send(MODE_MAG, 12'd0, 1'b0);
    send(MODE_READ, 12'd0, 1'b1);
    send(MODE_READ, 12'd4095, 1'b0);
    send(MODE_WRITE, 12'd0, 1'b0);
    send(MODE_WRITE, 12'd4095, 1'b1);
    send(MODE_WRITE, 12'd0, 1'b0);
    send(MODE_READ, 12'd0, 1'b0);
    send(MODE_CLUST, 12'd0, 1'b0);
    send(MODE_CLUST, 12'd4095, 1'b1);
    send(MODE_CLUST, 12'd63, 1'b0);
    send(MODE_MAG, 12'd4095, 1'b1);
    wait_drained();
    cfg_write(ADDR_THRESHOLD, 32'd0);
    cfg_write(ADDR_SEED, 32'd0);
    send(MODE_CLUST, 12'd100, 1'b0);
    send(MODE_CLUST, 12'd2080, 1'b1);
    wait_drained();
    cfg_write(ADDR_THRESHOLD, 32'h1FFFF);
    cfg_write(ADDR_SEED, 32'hFFFFFFFF);
    send(MODE_CLUST, 12'd5, 1'b0);
    send(MODE_READ, 12'd5, 1'b0);
    send(MODE_MAG, 12'd0, 1'b0);
    wait_drained();
    cfg_write(ADDR_THRESHOLD, 32'd65536);
    send(MODE_CLUST, 12'd7, 1'b0);
    wait_drained();
    cfg_write(ADDR_THRESHOLD, 32'd65535);
    cfg_write(ADDR_SEED, 32'h12345678);
    send(MODE_CLUST, 12'd2000, 1'b1);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: cfg_write(ADDR_THRESHOLD, 32'd2000);
        1: cfg_write(ADDR_THRESHOLD, 32'd20000);
        2: cfg_write(ADDR_THRESHOLD, 32'd30000);
        3: cfg_write(ADDR_THRESHOLD, 32'd8000);
        default: cfg_write(ADDR_THRESHOLD, $urandom_range(40000));
      endcase
      cfg_write(ADDR_SEED, $urandom);
      idle_pct = (ph == 2) ? 0 : 21;
      fork
        begin
          if (ph == 1) begin
            hold_off = 1;
            repeat (3000) @(posedge clk);
            hold_off = 0;
          end
        end
        begin
          for (int i = 0; i < 365; i++) rand_item();
        end
      join
      wait_drained();
    end
    if (fail_count == 0) $display("ising_wolff_cluster_flip verification clean");
    else $display("ising_wolff_cluster_flip verification failed");
    $finish;
  end

endmodule
